/* sv/mandelbrot_tile_escape_count_top_defines.svh */
// ----------------------------------------------------------------------------
// mandelbrot tile escape counter: assertion macros
// clocked on clk, disabled while rst_n is low; empty under synthesis
// ----------------------------------------------------------------------------
`ifndef MANDELBROT_TILE_ESCAPE_COUNT_TOP_DEFINES_SVH
`define MANDELBROT_TILE_ESCAPE_COUNT_TOP_DEFINES_SVH

`ifndef SYNTHESIS
// property must hold at every clock edge out of reset
`define MTEC_ASSERT(lbl, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);
// condition must never be seen at a clock edge out of reset
`define MTEC_NEVER(lbl, cond, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) !(cond)) else $error(msg);
`else
`define MTEC_ASSERT(lbl, prop, msg)
`define MTEC_NEVER(lbl, cond, msg)
`endif

`endif

/* sv/mtec_pkg.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mtec_pkg
// fixed-point widths, register indexes and the point type shared by the
// front end, the point queue and the iteration core
// ----------------------------------------------------------------------------
package mtec_pkg;

    // field widths
    localparam int COORD_W = 36;
    localparam int PIX_W   = 9;
    localparam int ZOOM_W  = 5;
    localparam int STEPS_W = 9;
    localparam int IDX_W   = 2;

    // fixed-point format: Q.28 coordinates, Q.56 products
    localparam int FRAC_BITS = 28;
    localparam int ZOOM_MAX  = 28;
    // c width: center plus pixel offset of up to 2^13 times 2^28
    localparam int C_W = 44;
    // signed pixel offset from the tile center
    localparam int OFF_W = 14;
    // z while not escaped stays within +-2 in Q.28
    localparam int Z_W = 31;
    localparam int P_W = 2 * Z_W;

    localparam logic signed [C_W-1:0] TWO_Q28     = 44'sd536870912;
    localparam logic signed [C_W-1:0] NEG_TWO_Q28 = -44'sd536870912;
    localparam logic signed [P_W-1:0] FOUR_Q56    = 62'sd288230376151711744;

    // configuration register indexes
    typedef enum logic [IDX_W-1:0] {
        REG_CENTER_REAL = 2'd0,
        REG_CENTER_IMAG = 2'd1,
        REG_ZOOM_LEVEL  = 2'd2
    } reg_idx_t;

    // point c handed from front end to core
    typedef struct packed {
        logic signed [C_W-1:0] cr;
        logic signed [C_W-1:0] ci;
    } cpt_t;

endpackage

/* sv/mtec_front.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mtec_front
// holds the tile registers and maps each accepted pixel to its point c
// ----------------------------------------------------------------------------
module mtec_front #(
    parameter int TILE_SIZE = 512
) (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          cfg_we,
    input  logic [mtec_pkg::IDX_W-1:0]    cfg_index,
    input  logic [mtec_pkg::COORD_W-1:0]  cfg_data,
    input  logic                          in_valid,
    input  logic [mtec_pkg::PIX_W-1:0]    pixel_col,
    input  logic [mtec_pkg::PIX_W-1:0]    pixel_row,
    input  logic                          q_full,
    output logic                          q_push,
    output mtec_pkg::cpt_t                q_data
);

    localparam int HALF = TILE_SIZE / 2;
    localparam logic signed [mtec_pkg::OFF_W-1:0] HALF_S = mtec_pkg::OFF_W'(HALF);

    logic signed [mtec_pkg::COORD_W-1:0] center_real_reg;
    logic signed [mtec_pkg::COORD_W-1:0] center_imag_reg;
    logic [mtec_pkg::ZOOM_W-1:0]         zoom_reg;
    logic [mtec_pkg::ZOOM_W-1:0]         shift;
    logic signed [mtec_pkg::OFF_W-1:0]   off_col;
    logic signed [mtec_pkg::OFF_W-1:0]   off_row;
    logic signed [mtec_pkg::C_W-1:0]     step_col;
    logic signed [mtec_pkg::C_W-1:0]     step_row;

    // configuration registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            center_real_reg <= '0;
            center_imag_reg <= '0;
            zoom_reg        <= '0;
        end
        else if (cfg_we)
        begin
            unique case (cfg_index)
                mtec_pkg::REG_CENTER_REAL: center_real_reg <= cfg_data;
                mtec_pkg::REG_CENTER_IMAG: center_imag_reg <= cfg_data;
                mtec_pkg::REG_ZOOM_LEVEL:  zoom_reg        <= cfg_data[mtec_pkg::ZOOM_W-1:0];
                default: ;
            endcase
        end
    end

    // pixel spacing shift, zoom clamped at one lsb
    always_comb
    begin
        if (zoom_reg > mtec_pkg::ZOOM_W'(mtec_pkg::ZOOM_MAX))
            shift = '0;
        else
            shift = mtec_pkg::ZOOM_W'(mtec_pkg::FRAC_BITS) - zoom_reg;
    end

    // offset from tile center scaled by the spacing
    assign off_col  = $signed(mtec_pkg::OFF_W'(pixel_col)) - HALF_S;
    assign off_row  = $signed(mtec_pkg::OFF_W'(pixel_row)) - HALF_S;
    assign step_col = mtec_pkg::C_W'(off_col) <<< shift;
    assign step_row = mtec_pkg::C_W'(off_row) <<< shift;

    // point c into the queue
    assign q_data.cr = mtec_pkg::C_W'(center_real_reg) + step_col;
    assign q_data.ci = mtec_pkg::C_W'(center_imag_reg) + step_row;
    assign q_push    = in_valid && !q_full;

endmodule

/* sv/mtec_queue.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mtec_queue
// two-entry queue of points between front end and iteration core
// ----------------------------------------------------------------------------
`include "mandelbrot_tile_escape_count_top_defines.svh"

module mtec_queue (
    input  logic            clk,
    input  logic            rst_n,
    input  logic            push,
    input  mtec_pkg::cpt_t  push_data,
    output logic            full,
    input  logic            pop,
    output logic            avail,
    output mtec_pkg::cpt_t  pop_data
);

    mtec_pkg::cpt_t mem [2];
    logic           wr_ptr_reg;
    logic           rd_ptr_reg;
    logic [1:0]     cnt_reg;
    logic [1:0]     cnt_next;

    assign full     = (cnt_reg == 2'd2);
    assign avail    = (cnt_reg != 2'd0);
    assign pop_data = mem[rd_ptr_reg];

    // entry storage
    always_ff @(posedge clk)
    begin
        if (push)
            mem[wr_ptr_reg] <= push_data;
    end

    // occupancy
    always_comb
    begin
        cnt_next = cnt_reg;
        if (push && !pop)
            cnt_next = cnt_reg + 2'd1;
        else if (pop && !push)
            cnt_next = cnt_reg - 2'd1;
    end

    // pointers and count
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            cnt_reg    <= 2'd0;
        end
        else
        begin
            if (push)
                wr_ptr_reg <= ~wr_ptr_reg;
            if (pop)
                rd_ptr_reg <= ~rd_ptr_reg;
            cnt_reg <= cnt_next;
        end
    end

    `MTEC_NEVER(a_q_over, cnt_reg == 2'd3, "point queue over capacity")
    `MTEC_NEVER(a_q_under, pop && (cnt_reg == 2'd0), "pop from empty point queue")

endmodule

/* sv/mtec_core.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mtec_core
// iterates z = z^2 + c for one point: products registered in the MUL state,
// update and escape test in the ADD state that follows; holds the result register
// ----------------------------------------------------------------------------
`include "mandelbrot_tile_escape_count_top_defines.svh"

module mtec_core #(
    parameter int MAX_ITER = 256
) (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          q_avail,
    input  mtec_pkg::cpt_t                q_data,
    output logic                          q_pop,
    output logic                          out_valid,
    input  logic                          out_stall,
    output logic [mtec_pkg::STEPS_W-1:0]  escape_steps
);

    localparam int CNT_W = $clog2(MAX_ITER + 1);
    localparam logic [CNT_W-1:0] LAST = CNT_W'(MAX_ITER);
    localparam logic signed [mtec_pkg::Z_W-1:0] Z_TWO = 31'sd536870912;

    typedef enum logic [2:0] {
        ST_IDLE = 3'b001,
        ST_MUL  = 3'b010,
        ST_ADD  = 3'b100
    } state_t;

    state_t                              state_reg, state_next;
    logic signed [mtec_pkg::C_W-1:0]     cr_reg, cr_next;
    logic signed [mtec_pkg::C_W-1:0]     ci_reg, ci_next;
    logic signed [mtec_pkg::Z_W-1:0]     zr_reg, zr_next;
    logic signed [mtec_pkg::Z_W-1:0]     zi_reg, zi_next;
    logic                                big_reg, big_next;
    logic [CNT_W-1:0]                    steps_reg, steps_next;
    logic signed [mtec_pkg::P_W-1:0]     prr_reg, pii_reg, pri_reg;
    logic                                out_valid_reg, out_valid_next;
    logic [mtec_pkg::STEPS_W-1:0]        out_steps_reg, out_steps_next;

    logic signed [mtec_pkg::P_W-1:0]     mag;
    logic signed [mtec_pkg::P_W-1:0]     re_q56;
    logic signed [mtec_pkg::P_W-1:0]     im_q56;
    logic signed [mtec_pkg::P_W-1:0]     re_q28;
    logic signed [mtec_pkg::P_W-1:0]     im_q28;
    logic signed [mtec_pkg::C_W-1:0]     nr;
    logic signed [mtec_pkg::C_W-1:0]     ni;
    logic                                escaped;
    logic                                finish;
    logic                                out_free;
    logic                                z_in_range;
    logic                                done_now;
    logic                                delivered;

    // squares and cross product of current z, registered
    always_ff @(posedge clk)
    begin
        if (state_reg == ST_MUL)
        begin
            prr_reg <= zr_reg * zr_reg;
            pii_reg <= zi_reg * zi_reg;
            pri_reg <= zr_reg * zi_reg;
        end
    end

    // next z: floor back to q.28, then add c
    assign re_q56 = prr_reg - pii_reg;
    assign im_q56 = pri_reg <<< 1;
    assign re_q28 = re_q56 >>> mtec_pkg::FRAC_BITS;
    assign im_q28 = im_q56 >>> mtec_pkg::FRAC_BITS;
    assign nr     = re_q28[mtec_pkg::C_W-1:0] + cr_reg;
    assign ni     = im_q28[mtec_pkg::C_W-1:0] + ci_reg;

    // escape test on the squares of the z last produced
    assign mag      = prr_reg + pii_reg;
    assign escaped  = (steps_reg != '0) && (big_reg || (mag > mtec_pkg::FOUR_Q56));
    assign finish   = escaped || (steps_reg == LAST);
    assign out_free = !out_valid_reg || !out_stall;
    assign q_pop    = (state_reg == ST_IDLE) && q_avail;

    // sequencer
    always_comb
    begin
        state_next     = state_reg;
        cr_next        = cr_reg;
        ci_next        = ci_reg;
        zr_next        = zr_reg;
        zi_next        = zi_reg;
        big_next       = big_reg;
        steps_next     = steps_reg;
        out_valid_next = out_valid_reg && out_stall;
        out_steps_next = out_steps_reg;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (q_avail)
                begin
                    cr_next    = q_data.cr;
                    ci_next    = q_data.ci;
                    zr_next    = '0;
                    zi_next    = '0;
                    big_next   = 1'b0;
                    steps_next = '0;
                    state_next = ST_MUL;
                end
            end
            ST_MUL:
            begin
                state_next = ST_ADD;
            end
            ST_ADD:
            begin
                if (finish)
                begin
                    // wait here until the result register is free
                    if (out_free)
                    begin
                        out_valid_next = 1'b1;
                        out_steps_next = mtec_pkg::STEPS_W'(steps_reg);
                        state_next     = ST_IDLE;
                    end
                end
                else
                begin
                    zr_next    = nr[mtec_pkg::Z_W-1:0];
                    zi_next    = ni[mtec_pkg::Z_W-1:0];
                    big_next   = (nr > mtec_pkg::TWO_Q28) || (nr < mtec_pkg::NEG_TWO_Q28) ||
                                 (ni > mtec_pkg::TWO_Q28) || (ni < mtec_pkg::NEG_TWO_Q28);
                    steps_next = steps_reg + CNT_W'(1);
                    state_next = ST_MUL;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // datapath registers
    always_ff @(posedge clk)
    begin
        cr_reg        <= cr_next;
        ci_reg        <= ci_next;
        zr_reg        <= zr_next;
        zi_reg        <= zi_next;
        big_reg       <= big_next;
        out_steps_reg <= out_steps_next;
    end

    // control registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            steps_reg     <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            steps_reg     <= steps_next;
            out_valid_reg <= out_valid_next;
        end
    end

    assign out_valid    = out_valid_reg;
    assign escape_steps = out_steps_reg;

    // terms for the checks below
    assign z_in_range = (zr_reg <= Z_TWO) && (zr_reg >= -Z_TWO) &&
                        (zi_reg <= Z_TWO) && (zi_reg >= -Z_TWO);
    assign done_now   = (state_reg == ST_ADD) && finish && out_free;
    assign delivered  = out_valid_reg && (state_reg == ST_IDLE);

    `MTEC_NEVER(a_steps_max, steps_reg > LAST, "step count past maximum")
    `MTEC_ASSERT(a_z_range, ((state_reg == ST_MUL) && !big_reg) |-> z_in_range, "z out of range")
    `MTEC_ASSERT(a_done_free, done_now |=> delivered, "finished point not delivered")

endmodule

/* sv/mandelbrot_tile_escape_count_top.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mandelbrot_tile_escape_count_top
// escape-time count for one pixel of a square tile, z = z^2 + c in q.28 from a q8.28 center
//
//   channel  direction  handshake              payload
//   cfg      in         cfg_valid / cfg_ready  cfg_index, cfg_data
//   in       in         in_valid / in_stall    pixel_col, pixel_row
//   out      out        out_valid / out_stall  escape_steps
//
// a pixel holds the core for a load state, then a product state (three 31x31
// multipliers) and an update / escape-test state per step, plus one more such
// pair whose test ends the run.
// the front end maps a pixel to c in the cycle it is taken; a two-entry
// queue lets up to two pixels wait behind the one in the core.
// a result held by out_stall keeps the core waiting; once the queue is full,
// in_stall rises. cfg_ready is always high; reset clears all tile registers.
// ----------------------------------------------------------------------------
module mandelbrot_tile_escape_count_top #(
    parameter int MAX_ITER  = 256,
    parameter int TILE_SIZE = 512
) (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          cfg_valid,
    output logic                          cfg_ready,
    input  logic [mtec_pkg::IDX_W-1:0]    cfg_index,
    input  logic [mtec_pkg::COORD_W-1:0]  cfg_data,
    input  logic                          in_valid,
    output logic                          in_stall,
    input  logic [mtec_pkg::PIX_W-1:0]    pixel_col,
    input  logic [mtec_pkg::PIX_W-1:0]    pixel_row,
    output logic                          out_valid,
    input  logic                          out_stall,
    output logic [mtec_pkg::STEPS_W-1:0]  escape_steps
);

    logic           q_full;
    logic           q_push;
    logic           q_pop;
    logic           q_avail;
    mtec_pkg::cpt_t q_in;
    mtec_pkg::cpt_t q_out;

    assign cfg_ready = 1'b1;
    assign in_stall  = q_full;

    // pixel to point mapping
    mtec_front #(
        .TILE_SIZE (TILE_SIZE)
    ) u_front (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_valid && cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .in_valid  (in_valid),
        .pixel_col (pixel_col),
        .pixel_row (pixel_row),
        .q_full    (q_full),
        .q_push    (q_push),
        .q_data    (q_in)
    );

    // point queue
    mtec_queue u_queue (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (q_push),
        .push_data (q_in),
        .full      (q_full),
        .pop       (q_pop),
        .avail     (q_avail),
        .pop_data  (q_out)
    );

    // escape iteration
    mtec_core #(
        .MAX_ITER (MAX_ITER)
    ) u_core (
        .clk          (clk),
        .rst_n        (rst_n),
        .q_avail      (q_avail),
        .q_data       (q_out),
        .q_pop        (q_pop),
        .out_valid    (out_valid),
        .out_stall    (out_stall),
        .escape_steps (escape_steps)
    );

endmodule
